@@ rtl/core/plpp_pkg.sv @@
// Shared types and constants for the piecewise-linear position predictor.
`timescale 1ns / 1ps
`default_nettype none

package plpp_pkg;

  // Table geometry
  localparam int MAX_SEGMENTS = 1024;
  localparam int SEG_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = SEG_W + 1;

  // Field widths
  localparam int KEY_W   = 64;
  localparam int COEF_W  = 64;
  localparam int POS_W   = 32;
  localparam int TOTAL_W = 33;

  // Accumulator in units of 2^-60: unsigned key times signed slope, plus room
  localparam int ACC_W  = 130;
  localparam int FRAC_W = 60;
  localparam int ISH    = 44;        // intercept Q.16 to Q.60
  localparam int BIAS   = 10;        // monotone lookup offset

  typedef enum logic [1:0] {
    CMD_WRITE      = 2'd0,
    CMD_SEARCH     = 2'd1,
    CMD_SCAN       = 2'd2,
    CMD_SET_CURSOR = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_FOUND  = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_NO_SEG = 2'd2
  } status_e;

  typedef enum logic {
    CFG_SEG_COUNT  = 1'b0,
    CFG_TOTAL_KEYS = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_SCMP,
    ST_SCAN,
    ST_LCMP,
    ST_MAC,
    ST_WAIT
  } state_e;

  // Request to the shared multiply-accumulate unit
  typedef struct packed {
    logic                     go;
    logic                     minus_ten;
    logic [KEY_W-1:0]         key;
    logic signed [COEF_W-1:0] slope;
    logic signed [COEF_W-1:0] intercept;
  } mac_req_t;

endpackage

`default_nettype wire

@@ rtl/core/plpp_mac.sv @@
// Iterative multiply-accumulate: key*slope + intercept (- bias) on a 32x32 multiplier.
`timescale 1ns / 1ps
`default_nettype none

module plpp_mac (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  plpp_pkg::mac_req_t             req_i,
  output logic                           done_o,
  output logic [plpp_pkg::ACC_W-1:0]     acc_o
);
  import plpp_pkg::*;

  localparam logic [2:0] STEP_FIRST = 3'd0;
  localparam logic [2:0] STEP_P00   = 3'd1;
  localparam logic [2:0] STEP_P01   = 3'd2;
  localparam logic [2:0] STEP_P10   = 3'd3;
  localparam logic [2:0] STEP_P11   = 3'd4;
  localparam logic [2:0] STEP_SIGN  = 3'd5;
  localparam logic [2:0] STEP_ICPT  = 3'd6;
  localparam logic [2:0] STEP_LAST  = 3'd7;

  logic              run_q;
  logic [2:0]        step_q;
  logic              done_q;
  logic [KEY_W-1:0]  a_q;
  logic [COEF_W-1:0] b_q;
  logic [COEF_W-1:0] c_q;
  logic              m_q;
  logic [63:0]       pp_q, pp_d;
  logic [ACC_W-1:0]  acc_q, addend;
  logic [31:0]       mul_a, mul_b;

  // Operand halves for the partial product of this step
  always_comb begin
    mul_a = a_q[31:0];
    mul_b = b_q[31:0];
    case (step_q)
      STEP_FIRST: begin mul_a = a_q[31:0];  mul_b = b_q[31:0];  end
      STEP_P00:   begin mul_a = a_q[31:0];  mul_b = b_q[63:32]; end
      STEP_P01:   begin mul_a = a_q[63:32]; mul_b = b_q[31:0];  end
      STEP_P10:   begin mul_a = a_q[63:32]; mul_b = b_q[63:32]; end
      default:    begin mul_a = a_q[31:0];  mul_b = b_q[31:0];  end
    endcase
    pp_d = {32'd0, mul_a} * {32'd0, mul_b};
  end

  // Term added to the accumulator in this step
  always_comb begin
    case (step_q)
      STEP_P00:  addend = ACC_W'(pp_q);
      STEP_P01:  addend = ACC_W'(pp_q) << 32;
      STEP_P10:  addend = ACC_W'(pp_q) << 32;
      STEP_P11:  addend = ACC_W'(pp_q) << 64;
      // unsigned product of a negative slope is 2^64*key too large
      STEP_SIGN: addend = b_q[COEF_W-1] ? -(ACC_W'(a_q) << 64) : '0;
      STEP_ICPT: addend = {{(ACC_W-COEF_W-ISH){c_q[COEF_W-1]}}, c_q, {ISH{1'b0}}};
      STEP_LAST: addend = m_q ? -(ACC_W'(BIAS) << FRAC_W) : '0;
      default:   addend = '0;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= STEP_FIRST;
      done_q <= 1'b0;
    end else begin
      done_q <= run_q && (step_q == STEP_LAST);
      if (req_i.go) begin
        run_q  <= 1'b1;
        step_q <= STEP_FIRST;
      end else if (run_q) begin
        step_q <= step_q + 3'd1;
        if (step_q == STEP_LAST) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  // Operands, product register and accumulator
  always_ff @(posedge clk_i) begin
    if (req_i.go) begin
      a_q <= req_i.key;
      b_q <= req_i.slope;
      c_q <= req_i.intercept;
      m_q <= req_i.minus_ten;
    end else if (run_q) begin
      pp_q  <= pp_d;
      acc_q <= (step_q == STEP_FIRST) ? '0 : acc_q + addend;
    end
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

`default_nettype wire

@@ rtl/core/piecewise_linear_position_predictor.sv @@
// Top level: segment table, binary search / cursor scan sequencer, clamp and result registers.
// Writes and cursor sets finish at the accepting edge; an empty table answers in the cycle after acceptance.
// Search: each halving step (10 at most) passes SRCH and SCMP; then the final read in SRCH and the 8-step MAC.
// Scan: each segment visited from the cursor passes SCAN and LCMP; a hit then runs the MAC, a miss ends in SCAN.
// Result strobe is in the first cycle with busy low; one command at a time, no result stall.
// Reset: segment_count=0, total_keys=1, cursor=0, no strobe; table contents stay unknown.
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_position_predictor (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // command channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           cmd_i,
  input  logic [plpp_pkg::CNT_W-1:0]           slot_i,
  input  logic [plpp_pkg::KEY_W-1:0]           query_key_i,
  input  logic [plpp_pkg::KEY_W-1:0]           start_key_i,
  input  logic [plpp_pkg::KEY_W-1:0]           last_key_i,
  input  logic signed [plpp_pkg::COEF_W-1:0]   slope_i,
  input  logic signed [plpp_pkg::COEF_W-1:0]   intercept_i,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_idx_i,
  input  logic [plpp_pkg::TOTAL_W-1:0]         cfg_wdata_i,
  // results
  output logic                                 done_o,
  output logic [plpp_pkg::POS_W-1:0]           position_o,
  output logic [plpp_pkg::SEG_W-1:0]           chosen_segment_o,
  output logic [1:0]                           status_o
);
  import plpp_pkg::*;

  // Segment table
  logic [KEY_W-1:0]  mem_start [MAX_SEGMENTS];
  logic [KEY_W-1:0]  mem_last  [MAX_SEGMENTS];
  logic [COEF_W-1:0] mem_slope [MAX_SEGMENTS];
  logic [COEF_W-1:0] mem_icpt  [MAX_SEGMENTS];
  logic [KEY_W-1:0]  rd_start_q, rd_last_q;
  logic [COEF_W-1:0] rd_slope_q, rd_icpt_q;
  logic [SEG_W-1:0]  rd_addr;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q;
  logic [TOTAL_W-1:0] total_q;
  logic [CNT_W-1:0]  cursor_q, cursor_d;
  logic [SEG_W-1:0]  lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, mid;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic              mono_q, mono_d;
  logic              done_q, done_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [SEG_W-1:0]  seg_q, seg_d;
  status_e           stat_q, stat_d;

  logic              accept, wr_en;
  cmd_e              cmd;
  logic [CNT_W-1:0]  n_valid;
  logic [TOTAL_W-1:0] total_m1;
  logic [POS_W-1:0]  mono_top, top_sel, clamped;
  logic [63:0]       ip;
  mac_req_t          mac_req;
  logic              mac_done;
  logic [ACC_W-1:0]  mac_acc;

  assign cmd    = cmd_e'(cmd_i);
  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign wr_en  = accept && (cmd == CMD_WRITE) && (slot_i < CNT_W'(MAX_SEGMENTS));

  // Usable segment count
  assign n_valid = (count_q > CNT_W'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS) : count_q;

  // Upper clamp of the monotone lookup
  assign total_m1 = total_q - TOTAL_W'(1);
  always_comb begin
    if (total_q == '0) begin
      mono_top = '0;
    end else if (total_m1[TOTAL_W-1]) begin
      mono_top = '1;
    end else begin
      mono_top = total_m1[POS_W-1:0];
    end
  end

  // Floor and clamp of the accumulated prediction
  assign top_sel = mono_q ? mono_top : '1;
  assign ip      = mac_acc[FRAC_W+63:FRAC_W];
  always_comb begin
    if (mac_acc[ACC_W-1]) begin
      clamped = '0;
    end else if ((|mac_acc[ACC_W-2:FRAC_W+64]) || (ip > {32'd0, top_sel})) begin
      clamped = top_sel;
    end else begin
      clamped = ip[POS_W-1:0];
    end
  end

  assign mid = SEG_W'((CNT_W'(lo_q) + CNT_W'(hi_q) + CNT_W'(1)) >> 1);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && n_valid != '0) begin
          if (cmd == CMD_SEARCH) begin
            state_d = ST_SRCH;
          end else if (cmd == CMD_SCAN) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SRCH: state_d = (lo_q < hi_q) ? ST_SCMP : ST_MAC;
      ST_SCMP: state_d = ST_SRCH;
      ST_SCAN: state_d = (idx_q >= n_valid) ? ST_IDLE : ST_LCMP;
      ST_LCMP: state_d = (rd_last_q > key_q) ? ST_WAIT : ST_SCAN;
      ST_MAC:  state_d = ST_WAIT;
      ST_WAIT: state_d = mac_done ? ST_IDLE : ST_WAIT;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs per state
  always_comb begin
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    idx_d    = idx_q;
    key_d    = key_q;
    mono_d   = mono_q;
    cursor_d = cursor_q;
    done_d   = 1'b0;
    pos_d    = pos_q;
    seg_d    = seg_q;
    stat_d   = stat_q;
    rd_addr  = lo_q;
    mac_req  = '{go: 1'b0, minus_ten: mono_q, key: key_q,
                 slope: rd_slope_q, intercept: rd_icpt_q};
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          key_d = query_key_i;
          case (cmd)
            CMD_SET_CURSOR: cursor_d = slot_i;
            CMD_SEARCH: begin
              mono_d = 1'b0;
              lo_d   = '0;
              hi_d   = SEG_W'(n_valid - CNT_W'(1));
              if (n_valid == '0) begin
                done_d = 1'b1;
                pos_d  = '0;
                seg_d  = '0;
                stat_d = STAT_EMPTY;
              end
            end
            CMD_SCAN: begin
              mono_d = 1'b1;
              idx_d  = cursor_q;
              if (n_valid == '0) begin
                done_d = 1'b1;
                pos_d  = mono_top;
                seg_d  = '0;
                stat_d = STAT_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SRCH: begin
        if (lo_q < hi_q) begin
          rd_addr = mid;
          mid_d   = mid;
        end else begin
          rd_addr = lo_q;
          seg_d   = lo_q;
        end
      end
      ST_SCMP: begin
        if (key_q < rd_start_q) begin
          hi_d = mid_q - SEG_W'(1);
        end else begin
          lo_d = mid_q;
        end
      end
      ST_SCAN: begin
        rd_addr = idx_q[SEG_W-1:0];
        if (idx_q >= n_valid) begin
          done_d = 1'b1;
          pos_d  = mono_top;
          seg_d  = '0;
          stat_d = STAT_NO_SEG;
        end
      end
      ST_LCMP: begin
        if (rd_last_q > key_q) begin
          mac_req.go = 1'b1;
          cursor_d   = idx_q;
          seg_d      = idx_q[SEG_W-1:0];
        end else begin
          idx_d = idx_q + CNT_W'(1);
        end
      end
      ST_MAC: mac_req.go = 1'b1;
      ST_WAIT: begin
        if (mac_done) begin
          done_d = 1'b1;
          pos_d  = clamped;
          stat_d = STAT_FOUND;
        end
      end
      default: ;
    endcase
  end

  // Table write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_start[slot_i[SEG_W-1:0]] <= start_key_i;
      mem_last[slot_i[SEG_W-1:0]]  <= last_key_i;
      mem_slope[slot_i[SEG_W-1:0]] <= slope_i;
      mem_icpt[slot_i[SEG_W-1:0]]  <= intercept_i;
    end
    rd_start_q <= mem_start[rd_addr];
    rd_last_q  <= mem_last[rd_addr];
    rd_slope_q <= mem_slope[rd_addr];
    rd_icpt_q  <= mem_icpt[rd_addr];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      total_q  <= TOTAL_W'(1);
      cursor_q <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cursor_q <= cursor_d;
      done_q   <= done_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SEG_COUNT:  count_q <= cfg_wdata_i[CNT_W-1:0];
          CFG_TOTAL_KEYS: total_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    idx_q  <= idx_d;
    key_q  <= key_d;
    mono_q <= mono_d;
    pos_q  <= pos_d;
    seg_q  <= seg_d;
    stat_q <= stat_d;
  end

  plpp_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .done_o (mac_done),
    .acc_o  (mac_acc)
  );

  assign done_o           = done_q;
  assign position_o       = pos_q;
  assign chosen_segment_o = seg_q;
  assign status_o         = stat_q;

  // Checks
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while a lookup is still running");

  a_mac_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> (state_q == ST_WAIT))
    else $error("multiply-accumulate finished outside the wait state");

  a_search_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCMP) |-> (lo_q < hi_q) && (mid_q > lo_q) && (mid_q <= hi_q))
    else $error("binary search bounds out of order");

  a_scan_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd == CMD_SCAN) && (n_valid != '0)) |=> busy && !done_o)
    else $error("monotone lookup did not start its scan");

endmodule

`default_nettype wire

@@ dv/piecewise_linear_position_predictor_tb.sv @@
// Self-checking testbench for the piecewise-linear position predictor: directed and random lookups.
`timescale 1ns / 1ps

module piecewise_linear_position_predictor_tb;
  import plpp_pkg::*;

  // One result transaction as seen on the result ports
  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [SEG_W-1:0] segment;
    status_e          status;
  } lookup_result_t;

  // One command transaction
  typedef struct {
    cmd_e               cmd;
    logic [CNT_W-1:0]   slot;
    logic [KEY_W-1:0]   query_key;
    logic [KEY_W-1:0]   start_key;
    logic [KEY_W-1:0]   last_key;
    logic [COEF_W-1:0]  slope;
    logic [COEF_W-1:0]  intercept;
  } command_t;

  localparam logic [POS_W-1:0]   POS_SAT    = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX  = '1;
  localparam logic [COEF_W-1:0]  ONE_Q60    = 64'h1000_0000_0000_0000;
  localparam logic [COEF_W-1:0]  COEF_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [COEF_W-1:0]  COEF_MIN   = 64'h8000_0000_0000_0000;
  localparam int                 END_CYCLES = 2100;  // longest scan plus margin

  // DUT signals, all driven from time zero
  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     start       = 1'b0;
  logic                     busy;
  logic [1:0]               cmd_i       = '0;
  logic [CNT_W-1:0]         slot_i      = '0;
  logic [KEY_W-1:0]         query_key_i = '0;
  logic [KEY_W-1:0]         start_key_i = '0;
  logic [KEY_W-1:0]         last_key_i  = '0;
  logic signed [COEF_W-1:0] slope_i     = '0;
  logic signed [COEF_W-1:0] intercept_i = '0;
  logic                     cfg_we_i    = 1'b0;
  logic                     cfg_idx_i   = 1'b0;
  logic [TOTAL_W-1:0]       cfg_wdata_i = '0;
  logic                     done_o;
  logic [POS_W-1:0]         position_o;
  logic [SEG_W-1:0]         chosen_segment_o;
  logic [1:0]               status_o;

  piecewise_linear_position_predictor u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .cmd_i            (cmd_i),
    .slot_i           (slot_i),
    .query_key_i      (query_key_i),
    .start_key_i      (start_key_i),
    .last_key_i       (last_key_i),
    .slope_i          (slope_i),
    .intercept_i      (intercept_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .done_o           (done_o),
    .position_o       (position_o),
    .chosen_segment_o (chosen_segment_o),
    .status_o         (status_o)
  );

  // Shadow segment table, cursor and registers
  logic [KEY_W-1:0]   tbl_start [MAX_SEGMENTS];
  logic [KEY_W-1:0]   tbl_last  [MAX_SEGMENTS];
  logic [COEF_W-1:0]  tbl_slope [MAX_SEGMENTS];
  logic [COEF_W-1:0]  tbl_icpt  [MAX_SEGMENTS];
  logic [CNT_W-1:0]   cursor_copy     = '0;
  logic [CNT_W-1:0]   seg_count_copy  = '0;
  logic [TOTAL_W-1:0] total_keys_copy = 1;

  lookup_result_t position_queue[$];
  lookup_result_t want_res, got_res;

  int  mismatch_count = 0;
  int  checked_count  = 0;
  int  n_items        = 0;
  int  n_search       = 0;
  int  n_scan         = 0;
  int  n_writes       = 0;
  int  n_cursor       = 0;
  int  status_seen [4];
  bit  idle_on        = 1'b1;

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit on run time
  initial begin
    #200_000_000;
    $display("** piecewise_linear_position_predictor: FAILED **");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // floor(key*slope + intercept [- bias]) in Q.60, clamped to [0, top]
  function automatic logic [POS_W-1:0] line_position(input int idx, input logic [KEY_W-1:0] key,
                                                     input bit minus_ten,
                                                     input logic [POS_W-1:0] top);
    logic signed [129:0] kx, sx, ix, acc;
    logic [63:0]         ip;
    kx  = {66'd0, key};
    sx  = {{66{tbl_slope[idx][63]}}, tbl_slope[idx]};
    ix  = {{66{tbl_icpt[idx][63]}}, tbl_icpt[idx]};
    acc = kx * sx + (ix <<< ISH);
    if (minus_ten) acc = acc - (130'sd10 <<< FRAC_W);
    if (acc[129]) return '0;
    if (acc[129:124] != '0) return top;
    ip = acc[123:60];
    return (ip > top) ? top : ip[POS_W-1:0];
  endfunction

  // Apply one accepted command to the shadow state; queue its result if any
  function automatic void predict_command(input command_t c);
    lookup_result_t     r;
    int                 n, lo, hi, mid, i;
    logic [TOTAL_W-1:0] t;
    logic [POS_W-1:0]   top;
    n = (seg_count_copy > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(seg_count_copy);
    n_items++;
    case (c.cmd)
      CMD_WRITE: begin
        n_writes++;
        if (c.slot < MAX_SEGMENTS) begin
          tbl_start[c.slot[SEG_W-1:0]] = c.start_key;
          tbl_last[c.slot[SEG_W-1:0]]  = c.last_key;
          tbl_slope[c.slot[SEG_W-1:0]] = c.slope;
          tbl_icpt[c.slot[SEG_W-1:0]]  = c.intercept;
        end
      end
      CMD_SET_CURSOR: begin
        n_cursor++;
        cursor_copy = c.slot;
      end
      CMD_SEARCH: begin
        n_search++;
        r.position = '0;
        r.segment  = '0;
        r.status   = STAT_EMPTY;
        if (n != 0) begin
          lo = 0;
          hi = n - 1;
          while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (c.query_key < tbl_start[mid]) hi = mid - 1;
            else lo = mid;
          end
          r.position = line_position(lo, c.query_key, 1'b0, POS_SAT);
          r.segment  = lo[SEG_W-1:0];
          r.status   = STAT_FOUND;
        end
        position_queue.push_back(r);
        status_seen[r.status]++;
      end
      default: begin
        n_scan++;
        t   = (total_keys_copy == '0) ? '0 : total_keys_copy - 1'b1;
        top = (t > POS_SAT) ? POS_SAT : t[POS_W-1:0];
        r.position = top;
        r.segment  = '0;
        r.status   = (n == 0) ? STAT_EMPTY : STAT_NO_SEG;
        if (n != 0) begin
          for (i = int'(cursor_copy); i < n; i++) begin
            if (tbl_last[i] > c.query_key) begin
              cursor_copy = CNT_W'(i);
              r.position  = line_position(i, c.query_key, 1'b1, top);
              r.segment   = i[SEG_W-1:0];
              r.status    = STAT_FOUND;
              break;
            end
          end
        end
        position_queue.push_back(r);
        status_seen[r.status]++;
      end
    endcase
  endfunction

  // Result checker: each strobe against the oldest pending prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      got_res.position = position_o;
      got_res.segment  = chosen_segment_o;
      got_res.status   = status_e'(status_o);
      if (position_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("[%0t] unexpected result pos=%0d seg=%0d st=%0d, nothing pending",
                   $realtime, position_o, chosen_segment_o, status_o);
      end else begin
        want_res = position_queue.pop_front();
        checked_count++;
        if (got_res.position !== want_res.position || got_res.segment !== want_res.segment ||
            got_res.status !== want_res.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] mismatch: exp pos=%0d seg=%0d st=%0d, got pos=%0d seg=%0d st=%0d",
                     $realtime, want_res.position, want_res.segment, want_res.status,
                     position_o, chosen_segment_o, status_o);
        end
      end
    end
  end

  // Random gap after a command: mostly none, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic command_t random_command();
    command_t c;
    c.cmd       = cmd_e'($urandom_range(0, 3));
    c.slot      = CNT_W'($urandom_range(0, 2047));
    c.query_key = rand64();
    c.start_key = rand64();
    c.last_key  = rand64();
    c.slope     = rand64();
    c.intercept = rand64();
    return c;
  endfunction

  // Slopes mostly within [-1, 1), some fully random
  function automatic logic [COEF_W-1:0] pick_slope();
    logic [COEF_W-1:0] s;
    int                r;
    r = $urandom_range(0, 99);
    s = rand64();
    if (r < 15) return s;
    s[63:60] = '0;
    return (r < 30) ? -s : s;
  endfunction

  // Intercepts mostly within +-2^24 positions, some fully random
  function automatic logic [COEF_W-1:0] pick_intercept();
    logic [COEF_W-1:0] t;
    t = rand64();
    if ($urandom_range(0, 99) < 15) return t;
    return {{24{t[63]}}, t[39:0]};
  endfunction

  // Key near or within the segments of the shadow table, an extreme, or fully random
  function automatic logic [KEY_W-1:0] pick_key(input int n);
    int j, r;
    j = $urandom_range(0, n - 1);
    r = $urandom_range(0, 99);
    if (r < 35) return tbl_start[j] + $urandom_range(0, 3);
    if (r < 45) return tbl_start[j] - 1;
    if (r < 60) return tbl_last[j] - $urandom_range(0, 1);
    if (r < 65) return '0;
    if (r < 70) return '1;
    if (r < 80) return rand64();
    return tbl_start[j] + $urandom_range(0, 1 << 24);
  endfunction

  // Drive one command at the falling edge, hold until accepted
  task automatic send_item(input command_t c);
    int gap;
    @(negedge clk_i);
    start       <= 1'b1;
    cmd_i       <= c.cmd;
    slot_i      <= c.slot;
    query_key_i <= c.query_key;
    start_key_i <= c.start_key;
    last_key_i  <= c.last_key;
    slope_i     <= c.slope;
    intercept_i <= c.intercept;
    do @(posedge clk_i); while (busy);
    predict_command(c);
    gap = pick_gap();
    repeat (gap) @(negedge clk_i) start <= 1'b0;
  endtask

  task automatic lookup(input cmd_e op, input logic [KEY_W-1:0] key);
    command_t c;
    c           = random_command();
    c.cmd       = op;
    c.query_key = key;
    send_item(c);
  endtask

  task automatic set_cursor(input logic [CNT_W-1:0] slot);
    command_t c;
    c      = random_command();
    c.cmd  = CMD_SET_CURSOR;
    c.slot = slot;
    send_item(c);
  endtask

  task automatic write_segment(input logic [CNT_W-1:0] slot, input logic [KEY_W-1:0] sk,
                               input logic [KEY_W-1:0] lk, input logic [COEF_W-1:0] sl,
                               input logic [COEF_W-1:0] ic);
    command_t c;
    c           = random_command();
    c.cmd       = CMD_WRITE;
    c.slot      = slot;
    c.start_key = sk;
    c.last_key  = lk;
    c.slope     = sl;
    c.intercept = ic;
    send_item(c);
  endtask

  // Stop sending and wait until every pending result has come back
  task automatic settle();
    @(negedge clk_i) start <= 1'b0;
    while (position_queue.size() != 0 || busy) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Register write, only with the block idle
  task automatic write_reg(input cfg_idx_e idx, input logic [TOTAL_W-1:0] value);
    settle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    if (idx == CFG_SEG_COUNT) seg_count_copy = value[CNT_W-1:0];
    else total_keys_copy = value;
    @(negedge clk_i) cfg_we_i <= 1'b0;
  endtask

  // Sorted segments 0..n-1, each ending where the next one starts
  task automatic write_table(input int n);
    logic [KEY_W-1:0] cur, nxt;
    int               i;
    cur = $urandom_range(0, 1 << 20);
    for (i = 0; i < n; i++) begin
      nxt = cur + $urandom_range(1, 1 << 24);
      if (i == n - 1 && $urandom_range(0, 3) == 0) nxt = '1;
      write_segment(CNT_W'(i), cur, nxt, pick_slope(), pick_intercept());
      cur = nxt;
    end
  endtask

  // Empty table: both lookups report status empty
  task automatic test_empty_table();
    idle_on = 1'b1;
    lookup(CMD_SEARCH, rand64());
    lookup(CMD_SEARCH, '0);
    lookup(CMD_SCAN, '1);
    set_cursor(5);
    lookup(CMD_SCAN, rand64());
    write_reg(CFG_TOTAL_KEYS, TOTAL_MAX);
    lookup(CMD_SCAN, rand64());
    lookup(CMD_SEARCH, '1);
  endtask

  // Full table, count at the maximum and above it
  task automatic test_table_fill();
    idle_on = 1'b1;
    write_table(MAX_SEGMENTS);
    write_reg(CFG_SEG_COUNT, MAX_SEGMENTS);
    write_reg(CFG_TOTAL_KEYS, 33'h0_0010_0000);
    lookup(CMD_SEARCH, '0);
    lookup(CMD_SEARCH, '1);
    lookup(CMD_SEARCH, pick_key(MAX_SEGMENTS));
    set_cursor(0);
    lookup(CMD_SCAN, tbl_start[512] + 1);
    lookup(CMD_SCAN, '1);
    write_reg(CFG_SEG_COUNT, 2047);
    lookup(CMD_SEARCH, pick_key(MAX_SEGMENTS));
    set_cursor(1000);
    lookup(CMD_SCAN, pick_key(MAX_SEGMENTS));
  endtask

  // Hand-built segments: extremes of slope and intercept, edges of every lookup
  task automatic test_directed_cases();
    idle_on = 1'b0;
    write_reg(CFG_SEG_COUNT, 4);
    write_reg(CFG_TOTAL_KEYS, 1000);
    write_segment(0, 100, 200, ONE_Q60, '0);
    write_segment(1, 200, 300, COEF_MAX, COEF_MAX);
    write_segment(2, 300, 400, COEF_MIN, COEF_MIN);
    write_segment(3, 400, '1, ONE_Q60 >> 1, 64'h5_0000);
    lookup(CMD_SEARCH, '0);        // below first segment: extrapolate segment 0
    lookup(CMD_SEARCH, 150);
    lookup(CMD_SEARCH, 250);       // saturates high
    lookup(CMD_SEARCH, 350);       // negative, clamps to zero
    lookup(CMD_SEARCH, '1);
    lookup(CMD_SEARCH, 400);
    set_cursor(0);
    lookup(CMD_SCAN, 150);
    lookup(CMD_SCAN, 5);           // bias drives it below zero
    lookup(CMD_SCAN, 350);         // cursor moves to segment 2
    lookup(CMD_SCAN, 150);         // cursor never moves back
    set_cursor(4);                 // cursor at the count
    lookup(CMD_SCAN, 150);
    set_cursor(2047);
    lookup(CMD_SCAN, 150);
    write_segment(1024, 1, 2, ONE_Q60, '0);   // writes past the table are dropped
    write_segment(2047, 1, 2, ONE_Q60, '0);
    set_cursor(3);
    lookup(CMD_SCAN, '1);          // last key is not above the key
    lookup(CMD_SCAN, 1000);
    // zero total keys, then a saturated upper clamp
    write_reg(CFG_TOTAL_KEYS, '0);
    set_cursor(0);
    lookup(CMD_SCAN, 1000);
    write_reg(CFG_TOTAL_KEYS, TOTAL_MAX);
    lookup(CMD_SCAN, 1000);
    set_cursor(1);
    lookup(CMD_SCAN, 250);
  endtask

  // One random phase: mostly well-formed lookups over a sorted table, some noise
  task automatic run_phase(input logic [CNT_W-1:0] count, input logic [TOTAL_W-1:0] total,
                           input int n_cmds, input bit rewrite, input bit idle);
    int               n, k, r, scan_pos, v;
    logic [KEY_W-1:0] key;
    idle_on = idle;
    n = (count > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(count);
    if (rewrite) write_table(n);
    write_reg(CFG_SEG_COUNT, count);
    write_reg(CFG_TOTAL_KEYS, total);
    scan_pos = 0;
    set_cursor(0);
    for (k = 0; k < n_cmds; k++) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        lookup(CMD_SEARCH, pick_key(n));
      end else if (r < 72) begin
        // ascending keys walk the cursor forward
        if ($urandom_range(0, 9) < 7) begin
          scan_pos += $urandom_range(0, 2);
          if (scan_pos > n - 1) scan_pos = n - 1;
          key = tbl_start[scan_pos] + $urandom_range(0, 7);
        end else begin
          key = pick_key(n);
        end
        lookup(CMD_SCAN, key);
      end else if (r < 82) begin
        if ($urandom_range(0, 9) < 6) begin
          scan_pos = 0;
          set_cursor(0);
        end else begin
          v = $urandom_range(0, 2047);
          scan_pos = (v > n - 1) ? n - 1 : v;
          set_cursor(CNT_W'(v));
        end
      end else if (r < 87) begin
        r = $urandom_range(0, 9);
        v = (r < 8) ? $urandom_range(0, n - 1) :
            (r < 9) ? $urandom_range(0, MAX_SEGMENTS - 1) : $urandom_range(1024, 2047);
        write_segment(CNT_W'(v), pick_key(n), pick_key(n), pick_slope(), pick_intercept());
      end else begin
        lookup((r < 94) ? CMD_SEARCH : CMD_SCAN, rand64());
      end
    end
  endtask

  task automatic test_random_traffic();
    int                 p;
    logic [TOTAL_W-1:0] total;
    run_phase(MAX_SEGMENTS, {1'b0, $urandom}, 60, 1'b0, 1'b1);
    run_phase(2047, TOTAL_MAX, 60, 1'b0, 1'b0);
    run_phase(1, 1, 150, 1'b1, 1'b1);
    for (p = 0; p < 7; p++) begin
      case (p % 4)
        0:       total = TOTAL_W'($urandom_range(1, 1 << 20));
        1:       total = (p == 1) ? '0 : {1'b1, 32'd0};
        2:       total = {1'($urandom_range(0, 1)), $urandom};
        default: total = TOTAL_W'($urandom_range(1, 1 << 16));
      endcase
      run_phase(CNT_W'($urandom_range(2, 64)), total, 45, 1'b1, (p % 3) != 0);
    end
  endtask

  // Reset, tests in turn, then drain and report
  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    test_empty_table();
    test_table_fill();
    test_directed_cases();
    test_random_traffic();
    settle();
    repeat (END_CYCLES) @(posedge clk_i);
    mismatch_count += position_queue.size();
    $display("Covered %0d commands: %0d searches, %0d scans, %0d writes, %0d cursor sets",
             n_items, n_search, n_scan, n_writes, n_cursor);
    $display("Checked %0d results: %0d found, %0d empty table, %0d none past cursor; %0d errors",
             checked_count, status_seen[STAT_FOUND], status_seen[STAT_EMPTY],
             status_seen[STAT_NO_SEG], mismatch_count);
    if (mismatch_count == 0) begin
      $display("** piecewise_linear_position_predictor: PASSED **");
    end else begin
      $display("** piecewise_linear_position_predictor: FAILED **");
    end
    $finish;
  end

endmodule
